[rtl/mbs_pkg.sv]
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants for the multidimensional bitmap store.
// ----------------------------------------------------------------------------
package mbs_pkg;

    localparam int IDX_FIELDS = 4;
    localparam int IDX_W      = 12;
    localparam int DSIZE_W    = 13;
    localparam int NDIMS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CNT_OUT_W  = 13;
    localparam int REQ_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3 = 3'd4;

    localparam logic [NDIMS_W-1:0] NUM_DIMS_RST = 3'd1;
    localparam logic [DSIZE_W-1:0] DIM0_RST     = 13'd4096;
    localparam logic [DSIZE_W-1:0] DIMN_RST     = 13'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_FILL  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FLAT,
        ST_READ,
        ST_MODIFY,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               clr;
        logic               step;
        logic [DSIZE_W-1:0] mult;
        logic [IDX_W-1:0]   idx;
    } t_flat_op;

endpackage

[rtl/mbs_flatten.sv]
// ----------------------------------------------------------------------------
// mbs_flatten
// Shared multiply-add unit, one flattening step per cycle while step is set,
// with saturation once the running index reaches or passes the store capacity.
// ----------------------------------------------------------------------------
module mbs_flatten #(
    parameter int TOTAL_BITS = 4096
) (
    input  logic                            i_clk,
    input  mbs_pkg::t_flat_op               i_op,
    output logic [$clog2(TOTAL_BITS)-1:0]   o_flat,
    output logic                            o_sat
);
    import mbs_pkg::*;

    localparam int AW = $clog2(TOTAL_BITS);
    localparam int SW = AW + DSIZE_W + 1;

    logic [AW-1:0] r_flat;
    logic          r_sat;
    logic [SW-1:0] w_sum;
    logic          n_sat;

    assign w_sum = SW'(r_flat) * SW'(i_op.mult) + SW'(i_op.idx);
    // a zero multiplier drops everything above, so saturation can end
    assign n_sat = (r_sat && (i_op.mult != '0)) || (w_sum >= SW'(TOTAL_BITS));

    always_ff @(posedge i_clk) begin
        if (i_op.clr) begin
            r_flat <= '0;
            r_sat  <= 1'b0;
        end else if (i_op.step) begin
            r_flat <= n_sat ? '0 : w_sum[AW-1:0];
            r_sat  <= n_sat;
        end
    end

    assign o_flat = r_flat;
    assign o_sat  = r_sat;

endmodule

[rtl/mbs_store.sv]
// ----------------------------------------------------------------------------
// mbs_store
// Single-port word memory with registered read data.
// ----------------------------------------------------------------------------
module mbs_store #(
    parameter int MEM_W     = 32,
    parameter int NUM_WORDS = 128,
    parameter int DW        = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [DW-1:0]    i_addr,
    input  logic [MEM_W-1:0] i_wdata,
    output logic [MEM_W-1:0] o_rdata
);
    logic [MEM_W-1:0] r_mem [NUM_WORDS];
    logic [MEM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/multidim_bitmap_store.sv]
// Read or write: n multiply-add steps, one memory read, one read-modify-write,
// then the result loads (past capacity it loads in place of the memory read);
// n = dimensions in use. Input stays stalled until the block is back in idle.
// Fill: one memory word per cycle. A stalled result holds off input.
// Reset: a clearing pass writes zero to all NUM_WORDS memory words, input
// stall held high meanwhile; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// multidim_bitmap_store
// Bit store addressed by up to four row-major indices with set-bit count.
// ----------------------------------------------------------------------------
module multidim_bitmap_store #(
    parameter int TOTAL_BITS = 4096,
    parameter int MAX_DIMS   = 4,
    parameter int WORD_BITS  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mbs_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mbs_pkg::IDX_W-1:0]          i_index_0,
    input  logic [mbs_pkg::IDX_W-1:0]          i_index_1,
    input  logic [mbs_pkg::IDX_W-1:0]          i_index_2,
    input  logic [mbs_pkg::IDX_W-1:0]          i_index_3,
    input  logic                               i_bit_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_old_bit,
    output logic                               o_out_of_range,
    output logic [mbs_pkg::CNT_OUT_W-1:0]      o_count_set
);
    import mbs_pkg::*;

    localparam int AW        = $clog2(TOTAL_BITS);
    localparam int OW        = $clog2(WORD_BITS);
    // word width rounded up to a power of two
    localparam int MEM_W     = 1 << OW;
    localparam int NUM_WORDS = (TOTAL_BITS + MEM_W - 1) / MEM_W;
    localparam int DW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW        = $clog2(TOTAL_BITS + 1);
    localparam int CXW       = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
    localparam int DIM_LIM   = (MAX_DIMS < IDX_FIELDS) ? MAX_DIMS : IDX_FIELDS;

    t_state               r_state, n_state;
    logic [NDIMS_W-1:0]   r_num_dims;
    logic [DSIZE_W-1:0]   r_dim_size [IDX_FIELDS];
    t_req                 r_req;
    logic [IDX_W-1:0]     r_idx [IDX_FIELDS];
    logic                 r_val;
    logic [1:0]           r_k;
    logic [DW-1:0]        r_sweep;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_res_old, r_res_oor;
    logic                 r_out_valid, r_out_old, r_out_oor;
    logic [CNT_OUT_W-1:0] r_out_count;

    logic                 w_in_acc, w_out_free, w_sweep_last;
    logic [1:0]           w_nm1;
    logic                 w_fin, w_fin_old, w_fin_oor;
    logic                 w_mem_we, w_mem_re;
    logic [DW-1:0]        w_mem_addr, w_addr;
    logic [MEM_W-1:0]     w_mem_wdata, w_rdata, w_mod_word;
    logic [OW-1:0]        w_bitpos;
    logic                 w_old;
    logic [AW-1:0]        w_flat;
    logic                 w_sat;
    logic [CXW-1:0]       w_cnt_ext;
    t_flat_op             w_op;

    mbs_flatten #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_flatten (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .o_flat (w_flat),
        .o_sat  (w_sat)
    );

    mbs_store #(
        .MEM_W     (MEM_W),
        .NUM_WORDS (NUM_WORDS),
        .DW        (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_sweep_last = (r_sweep == DW'(NUM_WORDS - 1));

    // dimensions in use minus one
    always_comb begin
        if (r_num_dims == '0) begin
            w_nm1 = 2'd0;
        end else if (int'(r_num_dims) > DIM_LIM) begin
            w_nm1 = 2'(DIM_LIM - 1);
        end else begin
            w_nm1 = 2'(r_num_dims - 3'd1);
        end
    end

    assign w_addr     = DW'(w_flat >> OW);
    assign w_bitpos   = ~w_flat[OW-1:0];
    assign w_old      = w_rdata[w_bitpos];
    assign w_mod_word = (w_rdata & ~(MEM_W'(1) << w_bitpos))
                      | (MEM_W'(r_val) << w_bitpos);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_fin       = 1'b0;
        w_fin_old   = 1'b0;
        w_fin_oor   = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = w_addr;
        w_mem_wdata = w_mod_word;
        w_op.clr    = w_in_acc;
        w_op.step   = 1'b0;
        w_op.mult   = r_dim_size[r_k];
        w_op.idx    = r_idx[r_k];
        case (r_state)
            ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_sweep;
                w_mem_wdata = '0;
                if (w_sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_req_type)
                        REQ_WRITE, REQ_READ: n_state = ST_FLAT;
                        REQ_FILL:            n_state = ST_FILL;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_FLAT: begin
                w_op.step = 1'b1;
                if (r_k == 2'd0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_sat) begin
                    w_fin     = 1'b1;
                    w_fin_oor = 1'b1;
                end else begin
                    w_mem_re = 1'b1;
                    n_state  = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                w_fin     = 1'b1;
                w_fin_old = w_old;
                if (r_req == REQ_WRITE) begin
                    w_mem_we = 1'b1;
                    if (r_val && !w_old) begin
                        n_count = r_count + CW'(1);
                    end else if (!r_val && w_old) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            ST_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_sweep;
                w_mem_wdata = {MEM_W{r_val}};
                if (w_sweep_last) begin
                    w_fin   = 1'b1;
                    n_count = r_val ? CW'(TOTAL_BITS) : '0;
                end
            end
            ST_DONE: begin
                w_fin     = 1'b1;
                w_fin_old = r_res_old;
                w_fin_oor = r_res_oor;
            end
            default: n_state = ST_IDLE;
        endcase
        if (w_fin) begin
            n_state = w_out_free ? ST_IDLE : ST_DONE;
        end
    end

    assign w_cnt_ext = CXW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_sweep       <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_num_dims    <= NUM_DIMS_RST;
            r_dim_size[0] <= DIM0_RST;
            r_dim_size[1] <= DIMN_RST;
            r_dim_size[2] <= DIMN_RST;
            r_dim_size[3] <= DIMN_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_mem_we && ((r_state == ST_CLEAR) || (r_state == ST_FILL))) begin
                r_sweep <= w_sweep_last ? '0 : r_sweep + DW'(1);
            end
            if (w_fin && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUM_DIMS:   r_num_dims    <= i_cfg_data[NDIMS_W-1:0];
                    CFG_DIM_SIZE_0: r_dim_size[0] <= i_cfg_data;
                    CFG_DIM_SIZE_1: r_dim_size[1] <= i_cfg_data;
                    CFG_DIM_SIZE_2: r_dim_size[2] <= i_cfg_data;
                    CFG_DIM_SIZE_3: r_dim_size[3] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req     <= t_req'(i_req_type);
            r_idx[0]  <= i_index_0;
            r_idx[1]  <= i_index_1;
            r_idx[2]  <= i_index_2;
            r_idx[3]  <= i_index_3;
            r_val     <= i_bit_value;
            r_k       <= w_nm1;
            r_res_old <= 1'b0;
            r_res_oor <= 1'b0;
        end else begin
            if ((r_state == ST_FLAT) && (r_k != 2'd0)) begin
                r_k <= r_k - 2'd1;
            end
            if (w_fin) begin
                r_res_old <= w_fin_old;
                r_res_oor <= w_fin_oor;
            end
        end
        if (w_fin && w_out_free) begin
            r_out_old   <= w_fin_old;
            r_out_oor   <= w_fin_oor;
            r_out_count <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_old_bit      = r_out_old;
    assign o_out_of_range = r_out_oor;
    assign o_count_set    = r_out_count;

endmodule

[rtl/mbs_checker.sv]
// ----------------------------------------------------------------------------
// mbs_checker
// Port-level checks for the multidimensional bitmap store.
// ----------------------------------------------------------------------------
module mbs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [mbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [mbs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [mbs_pkg::REQ_W-1:0]          i_req_type,
    input logic [mbs_pkg::IDX_W-1:0]          i_index_0,
    input logic [mbs_pkg::IDX_W-1:0]          i_index_1,
    input logic [mbs_pkg::IDX_W-1:0]          i_index_2,
    input logic [mbs_pkg::IDX_W-1:0]          i_index_3,
    input logic                               i_bit_value,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_old_bit,
    input logic                               o_out_of_range,
    input logic [mbs_pkg::CNT_OUT_W-1:0]      o_count_set
);

    // busy after every accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    // a result only follows an accepted word
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(o_in_stall) && !$past(i_in_valid) |-> !$rose(o_out_valid))
        else $error("result with no request");

    // out-of-range access never reports a stored bit
    a_oor_old_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> !o_old_bit)
        else $error("out-of-range result with old bit set");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_old_bit)
            && $stable(o_out_of_range) && $stable(o_count_set))
        else $error("stalled result changed");

endmodule

bind multidim_bitmap_store mbs_checker u_mbs_checker (.*);

[tb/multidim_bitmap_store_tb.sv]
// ----------------------------------------------------------------------------
// multidim_bitmap_store_tb
// Self-checking bench for the multidimensional bitmap store. A queue-fed
// driver sends write, read, fill and no-op requests in random bursts while
// the result side stalls on its own pattern. A shadow bit store predicts
// old bit, range flag and set-bit count for every word, across several
// dimension settings including zero and oversized multipliers.
// ----------------------------------------------------------------------------
module multidim_bitmap_store_tb;
    import mbs_pkg::*;

    localparam int STORE_BITS     = 4096;
    localparam int DIMS_LIMIT     = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 150;
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]                 req;
        logic [IDX_FIELDS-1:0][IDX_W-1:0] idx;
        logic                             val;
    } t_bit_req;

    typedef struct packed {
        logic                 old_bit;
        logic                 out_of_range;
        logic [CNT_OUT_W-1:0] count_set;
    } t_reply;

    typedef enum logic [1:0] {
        STALL_OFF,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [REQ_W-1:0]      i_req_type     = '0;
    logic [IDX_W-1:0]      i_index_0      = '0;
    logic [IDX_W-1:0]      i_index_1      = '0;
    logic [IDX_W-1:0]      i_index_2      = '0;
    logic [IDX_W-1:0]      i_index_3      = '0;
    logic                  i_bit_value    = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic                  o_old_bit;
    logic                  o_out_of_range;
    logic [CNT_OUT_W-1:0]  o_count_set;

    multidim_bitmap_store dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_index_0      (i_index_0),
        .i_index_1      (i_index_1),
        .i_index_2      (i_index_2),
        .i_index_3      (i_index_3),
        .i_bit_value    (i_bit_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_old_bit      (o_old_bit),
        .o_out_of_range (o_out_of_range),
        .o_count_set    (o_count_set)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow state
    logic                 shadow_bits [STORE_BITS];
    int unsigned          shadow_count;
    logic [NDIMS_W-1:0]   shadow_ndims;
    logic [DSIZE_W-1:0]   shadow_dim [IDX_FIELDS];

    t_bit_req request_q [$];
    t_reply   pending_replies [$];
    t_bit_req drv_word;
    t_bit_req seen_word;
    t_reply   want_reply;
    t_reply   got_reply;
    logic     req_taken   = 1'b0;
    int       burst_left  = 1;
    int       gap_left    = 0;
    int       stall_tick  = 0;
    int       idle_cycles = 0;
    int       errors      = 0;

    function automatic t_reply predict_bit_access(input t_bit_req r);
        t_reply            res;
        longint unsigned   flat;
        int                n;
        res = '0;
        if (r.req == REQ_FILL) begin
            foreach (shadow_bits[i]) shadow_bits[i] = r.val;
            shadow_count = r.val ? STORE_BITS : 0;
        end else if (r.req == REQ_WRITE || r.req == REQ_READ) begin
            n = (shadow_ndims == 0) ? 1 : ((shadow_ndims > DIMS_LIMIT) ? DIMS_LIMIT : shadow_ndims);
            flat = r.idx[n-1];
            for (int k = n - 2; k >= 0; k--) begin
                flat = flat * shadow_dim[k] + r.idx[k];
            end
            if (flat >= STORE_BITS) begin
                res.out_of_range = 1'b1;
            end else begin
                res.old_bit = shadow_bits[flat];
                if (r.req == REQ_WRITE) begin
                    if (r.val && !res.old_bit) shadow_count++;
                    else if (!r.val && res.old_bit) shadow_count--;
                    shadow_bits[flat] = r.val;
                end
            end
        end
        res.count_set = shadow_count[CNT_OUT_W-1:0];
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input int hot);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return IDX_W'($urandom_range(0, hot));
        if (r < 92) return IDX_W'($urandom_range(0, 4095));
        if (r < 96) return {IDX_W{1'b1}};
        return '0;
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] req, input int i0, input int i1,
                            input int i2, input int i3, input logic v);
        t_bit_req r;
        r.req = req;
        r.idx[0] = IDX_W'(i0);
        r.idx[1] = IDX_W'(i1);
        r.idx[2] = IDX_W'(i2);
        r.idx[3] = IDX_W'(i3);
        r.val = v;
        request_q.push_back(r);
    endtask

    task automatic push_random(input int count, input int h0, input int h1,
                               input int h2, input int h3);
        int r;
        logic [REQ_W-1:0] req;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 46) req = REQ_WRITE;
            else if (r < 90) req = REQ_READ;
            else if (r < 96) req = REQ_FILL;
            else req = REQ_NONE;
            push_req(req, pick_index(h0), pick_index(h1), pick_index(h2), pick_index(h3),
                     1'($urandom_range(0, 1)));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NUM_DIMS:   shadow_ndims  = data[NDIMS_W-1:0];
            CFG_DIM_SIZE_0: shadow_dim[0] = data;
            CFG_DIM_SIZE_1: shadow_dim[1] = data;
            CFG_DIM_SIZE_2: shadow_dim[2] = data;
            CFG_DIM_SIZE_3: shadow_dim[3] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int nd, input int d0, input int d1, input int d2, input int d3);
        cfg_write(CFG_NUM_DIMS, CFG_DATA_W'(nd));
        cfg_write(CFG_DIM_SIZE_0, CFG_DATA_W'(d0));
        cfg_write(CFG_DIM_SIZE_1, CFG_DATA_W'(d1));
        cfg_write(CFG_DIM_SIZE_2, CFG_DATA_W'(d2));
        cfg_write(CFG_DIM_SIZE_3, CFG_DATA_W'(d3));
    endtask

    task automatic wait_drain();
        while (request_q.size() != 0 || i_in_valid || pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_in_valid || req_taken) begin
            if (gap_left > 0 || request_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left = gap_left - 1;
            end else begin
                drv_word = request_q.pop_front();
                i_in_valid  <= 1'b1;
                i_req_type  <= drv_word.req;
                i_index_0   <= drv_word.idx[0];
                i_index_1   <= drv_word.idx[1];
                i_index_2   <= drv_word.idx[2];
                i_index_3   <= drv_word.idx[3];
                i_bit_value <= drv_word.val;
                burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // result-side stall pattern
    always @(negedge i_clk) begin
        stall_tick = stall_tick + 1;
        case (t_stall_mode'((stall_tick / 101) % 4))
            STALL_OFF:      i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            default:        i_out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // predict on accept, check on result, watchdog
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen_word.req    = i_req_type;
            seen_word.idx[0] = i_index_0;
            seen_word.idx[1] = i_index_1;
            seen_word.idx[2] = i_index_2;
            seen_word.idx[3] = i_index_3;
            seen_word.val    = i_bit_value;
            pending_replies.push_back(predict_bit_access(seen_word));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_reply = '{o_old_bit, o_out_of_range, o_count_set};
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected word old_bit=%0d out_of_range=%0d count_set=%0d",
                         $time, o_old_bit, o_out_of_range, o_count_set);
                errors++;
            end else begin
                want_reply = pending_replies.pop_front();
                if (got_reply !== want_reply) begin
                    $display("%0t: mismatch expected old_bit=%0d out_of_range=%0d count_set=%0d",
                             $time, want_reply.old_bit, want_reply.out_of_range,
                             want_reply.count_set);
                    $display("%0t:          actual old_bit=%0d out_of_range=%0d count_set=%0d",
                             $time, got_reply.old_bit, got_reply.out_of_range,
                             got_reply.count_set);
                    errors++;
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
        shadow_count  = 0;
        shadow_ndims  = NUM_DIMS_RST;
        shadow_dim[0] = DIM0_RST;
        shadow_dim[1] = DIMN_RST;
        shadow_dim[2] = DIMN_RST;
        shadow_dim[3] = DIMN_RST;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: flat index is index_0
        push_req(REQ_WRITE, 0,    0,    0,    0,    1'b1);
        push_req(REQ_WRITE, 4095, 4095, 4095, 4095, 1'b1);
        push_req(REQ_READ,  0,    0,    0,    0,    1'b0);
        push_req(REQ_WRITE, 0,    0,    0,    0,    1'b1);
        push_req(REQ_WRITE, 4095, 0,    0,    0,    1'b0);
        push_req(REQ_WRITE, 4095, 0,    0,    0,    1'b0);
        push_req(REQ_READ,  4095, 0,    0,    0,    1'b1);
        push_req(REQ_WRITE, 31,   0,    0,    0,    1'b1);
        push_req(REQ_WRITE, 32,   0,    0,    0,    1'b1);
        push_req(REQ_READ,  33,   0,    0,    0,    1'b0);
        push_req(REQ_NONE,  31,   0,    0,    0,    1'b1);
        push_req(REQ_FILL,  0,    0,    0,    0,    1'b1);
        push_req(REQ_READ,  1234, 0,    0,    0,    1'b0);
        push_req(REQ_WRITE, 5,    0,    0,    0,    1'b0);
        push_req(REQ_WRITE, 5,    0,    0,    0,    1'b1);
        push_req(REQ_NONE,  4095, 4095, 4095, 4095, 1'b0);
        push_req(REQ_FILL,  4095, 0,    0,    0,    1'b0);
        push_req(REQ_READ,  4095, 0,    0,    0,    1'b0);
        push_req(REQ_FILL,  0,    0,    0,    0,    1'b0);
        push_random(84, 63, 4095, 4095, 4095);
        wait_drain();

        set_config(2, 64, 64, 4096, 1);
        push_req(REQ_WRITE, 0,    64,   0,    0,    1'b1);
        push_req(REQ_READ,  0,    64,   0,    0,    1'b0);
        push_req(REQ_WRITE, 63,   63,   0,    0,    1'b1);
        push_req(REQ_READ,  4095, 0,    0,    0,    1'b0);
        push_random(84, 63, 64, 4095, 4095);
        wait_drain();

        set_config(4, 16, 16, 16, 4096);
        push_random(84, 15, 15, 15, 1);
        wait_drain();

        set_config(0, 0, 0, 0, 0);
        push_random(84, 127, 4095, 4095, 4095);
        wait_drain();

        set_config(7, 8191, 8191, 8191, 8191);
        push_random(84, 4095, 0, 0, 0);
        wait_drain();

        set_config(3, 0, 4096, 1, 1);
        push_random(84, 31, 4095, 4095, 0);
        wait_drain();

        set_config(5, 1, 1, 1, 1);
        push_random(84, 1023, 1023, 1023, 1023);
        wait_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
